>>> rtl/mma_pkg.sv
// Shared types, widths, command codes and pipeline stage numbers for the
// Montgomery modular ALU. No dependencies.
package mma_pkg;

  localparam int WORD_WIDTH      = 64;
  localparam int HALF_WIDTH      = WORD_WIDTH / 2;
  localparam int CFG_INDEX_WIDTH = 1;

  typedef logic [WORD_WIDTH-1:0]      word_t;
  typedef logic [HALF_WIDTH-1:0]      half_t;
  typedef logic [2*WORD_WIDTH-1:0]    dword_t;
  typedef logic [1:0]                 cmd_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cmd_t CMD_MUL  = 2'd0;
  localparam cmd_t CMD_ADD  = 2'd1;
  localparam cmd_t CMD_SUB  = 2'd2;
  localparam cmd_t CMD_NONE = 2'd3;

  localparam cfg_index_t REG_MODULUS = 1'd0;
  localparam cfg_index_t REG_FACTOR  = 1'd1;

  // Karatsuba multiplier occupies three stages.
  localparam int KMUL_STAGES = 3;

  // Stage numbers: register k loads from stage k-1.
  localparam int ST_IN       = 1;
  localparam int ST_SUMDIFF  = 2;
  localparam int ST_ALT      = 3;
  localparam int ST_T        = 4;
  localparam int ST_Q        = 5;
  localparam int ST_U        = 6;
  localparam int ST_P        = 9;
  localparam int ST_S        = 10;
  localparam int NUM_STAGES  = 11;

endpackage

>>> rtl/mma_kmul.sv
// Three-stage Karatsuba multiplier, WORD_WIDTH x WORD_WIDTH to full product.
// Depends on mma_pkg; stage enables come from the enclosing pipeline.
module mma_kmul (
  input  logic                                clk,
  input  logic [mma_pkg::KMUL_STAGES-1:0]     en,
  input  mma_pkg::word_t                      x,
  input  mma_pkg::word_t                      y,
  output mma_pkg::dword_t                     prod
);
  import mma_pkg::*;

  logic [HALF_WIDTH:0]     x_sum;
  logic [HALF_WIDTH:0]     y_sum;
  word_t                   p00_a;
  word_t                   p11_a;
  logic [2*HALF_WIDTH+1:0] pm_a;
  word_t                   p00_b;
  word_t                   p11_b;
  logic [2*HALF_WIDTH+1:0] mid_b;

  assign x_sum = {1'b0, x[HALF_WIDTH-1:0]} + {1'b0, x[WORD_WIDTH-1:HALF_WIDTH]};
  assign y_sum = {1'b0, y[HALF_WIDTH-1:0]} + {1'b0, y[WORD_WIDTH-1:HALF_WIDTH]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p00_a <= {{HALF_WIDTH{1'b0}}, x[HALF_WIDTH-1:0]}
             * {{HALF_WIDTH{1'b0}}, y[HALF_WIDTH-1:0]};
      p11_a <= {{HALF_WIDTH{1'b0}}, x[WORD_WIDTH-1:HALF_WIDTH]}
             * {{HALF_WIDTH{1'b0}}, y[WORD_WIDTH-1:HALF_WIDTH]};
      pm_a  <= {{(HALF_WIDTH+1){1'b0}}, x_sum} * {{(HALF_WIDTH+1){1'b0}}, y_sum};
    end
    if (en[1]) begin
      p00_b <= p00_a;
      p11_b <= p11_a;
      mid_b <= pm_a - {2'b00, p00_a} - {2'b00, p11_a};
    end
    if (en[2]) begin
      prod <= {p11_b, p00_b} + dword_t'({mid_b, {HALF_WIDTH{1'b0}}});
    end
  end

endmodule

>>> rtl/montgomery_modular_alu.sv
// Top level of the Montgomery modular ALU: multiply with Montgomery
// reduction, modular add and subtract. Depends on mma_pkg and mma_kmul.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   command, operand_a, operand_b
//  out      source     out_valid / out_stall result
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; eleven register
// stages, holding the two three-stage Karatsuba multipliers, the reduction
// factor multiply and the final wide add and correction.
// Reset (synchronous) empties the pipeline, sets modulus to 1 and the factor
// to all ones. A stalled output holds; empty stages keep filling behind it.
module montgomery_modular_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  mma_pkg::cmd_t           command,
  input  mma_pkg::word_t          operand_a,
  input  mma_pkg::word_t          operand_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mma_pkg::word_t          result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  mma_pkg::cfg_index_t     cfg_index,
  input  mma_pkg::word_t          cfg_data
);
  import mma_pkg::*;

  word_t                    modulus;
  word_t                    factor;
  logic [NUM_STAGES:1]      valid_q;
  logic [NUM_STAGES+1:1]    en;
  cmd_t                     cmd_q [NUM_STAGES:1];
  word_t                    a_q;
  word_t                    b_q;
  logic [WORD_WIDTH:0]      sum_q;
  logic [WORD_WIDTH:0]      diff_q;
  word_t                    alt_q [ST_S:ST_ALT];
  dword_t                   t_prod;
  dword_t                   t_q [ST_P:ST_Q];
  word_t                    q00_q;
  half_t                    q01_q;
  half_t                    q10_q;
  word_t                    u_q;
  dword_t                   p_prod;
  logic [2*WORD_WIDTH:0]    s_sum;
  word_t                    mont_q;
  logic                     carry_q;
  word_t                    alt_next;
  word_t                    result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= word_t'(1);
      factor  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_FACTOR:  factor  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next one moves.
  always_comb begin
    en[NUM_STAGES+1] = !out_stall;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall  = !en[ST_IN];
  assign out_valid = valid_q[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en[ST_IN]) valid_q[ST_IN] <= in_valid;
      for (int k = ST_IN + 1; k <= NUM_STAGES; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      cmd_q[ST_IN] <= command;
      a_q          <= operand_a;
      b_q          <= operand_b;
    end
    for (int k = ST_IN + 1; k <= NUM_STAGES; k++) begin
      if (en[k]) cmd_q[k] <= cmd_q[k-1];
    end
  end

  // Add / subtract path
  always_comb begin
    case (cmd_q[ST_SUMDIFF])
      CMD_ADD: begin
        if (sum_q[WORD_WIDTH] || (sum_q[WORD_WIDTH-1:0] >= modulus)) begin
          alt_next = sum_q[WORD_WIDTH-1:0] - modulus;
        end else begin
          alt_next = sum_q[WORD_WIDTH-1:0];
        end
      end
      CMD_SUB: begin
        if (diff_q[WORD_WIDTH]) begin
          alt_next = diff_q[WORD_WIDTH-1:0] + modulus;
        end else begin
          alt_next = diff_q[WORD_WIDTH-1:0];
        end
      end
      default: alt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUMDIFF]) begin
      sum_q  <= {1'b0, a_q} + {1'b0, b_q};
      diff_q <= {1'b0, a_q} - {1'b0, b_q};
    end
    if (en[ST_ALT]) alt_q[ST_ALT] <= alt_next;
    for (int k = ST_ALT + 1; k <= ST_S; k++) begin
      if (en[k]) alt_q[k] <= alt_q[k-1];
    end
  end

  // Montgomery multiply path
  mma_kmul u_kmul_ab (
    .clk  (clk),
    .en   (en[ST_T:ST_SUMDIFF]),
    .x    (a_q),
    .y    (b_q),
    .prod (t_prod)
  );

  always_ff @(posedge clk) begin
    if (en[ST_Q]) begin
      t_q[ST_Q] <= t_prod;
      q00_q <= {{HALF_WIDTH{1'b0}}, t_prod[HALF_WIDTH-1:0]}
             * {{HALF_WIDTH{1'b0}}, factor[HALF_WIDTH-1:0]};
      q01_q <= t_prod[HALF_WIDTH-1:0] * factor[WORD_WIDTH-1:HALF_WIDTH];
      q10_q <= t_prod[WORD_WIDTH-1:HALF_WIDTH] * factor[HALF_WIDTH-1:0];
    end
    for (int k = ST_Q + 1; k <= ST_P; k++) begin
      if (en[k]) t_q[k] <= t_q[k-1];
    end
    if (en[ST_U]) u_q <= q00_q + {half_t'(q01_q + q10_q), {HALF_WIDTH{1'b0}}};
  end

  mma_kmul u_kmul_um (
    .clk  (clk),
    .en   (en[ST_P:ST_U+1]),
    .x    (u_q),
    .y    (modulus),
    .prod (p_prod)
  );

  assign s_sum = {1'b0, t_q[ST_P]} + {1'b0, p_prod};

  always_ff @(posedge clk) begin
    if (en[ST_S]) begin
      mont_q  <= s_sum[2*WORD_WIDTH-1:WORD_WIDTH];
      carry_q <= s_sum[2*WORD_WIDTH];
    end
  end

  always_comb begin
    if (cmd_q[ST_S] == CMD_MUL) begin
      if (carry_q || (mont_q >= modulus)) begin
        result_next = mont_q - modulus;
      end else begin
        result_next = mont_q;
      end
    end else begin
      result_next = alt_q[ST_S];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES]) result <= result_next;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&valid_q) && out_stall))
    else $error("input stalled while pipeline has a free stage");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid_q[ST_IN])
    else $error("accepted transaction not captured");

  a_unused_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cmd_q[NUM_STAGES] == CMD_NONE)) |-> (result == '0))
    else $error("unused command produced a nonzero result");

  a_no_drop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (valid_q[ST_S] && !en[ST_S]) |=> valid_q[ST_S])
    else $error("held stage lost its transaction");

endmodule
